### hdl/sip_pkg.sv
package sip_pkg;

    // control that travels alongside each request through the divider
    typedef struct packed {
        logic valid;
        logic hit;
        logic full;   // u_num equals den, fraction is exactly one
    } t_ctl;

endpackage

### hdl/sip_cross.sv
module sip_cross #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [COORD_BITS-1:0]  i_x1,
    input  logic signed [COORD_BITS-1:0]  i_y1,
    input  logic signed [COORD_BITS-1:0]  i_x2,
    input  logic signed [COORD_BITS-1:0]  i_y2,
    input  logic signed [COORD_BITS-1:0]  i_x3,
    input  logic signed [COORD_BITS-1:0]  i_y3,
    input  logic signed [COORD_BITS-1:0]  i_x4,
    input  logic signed [COORD_BITS-1:0]  i_y4,
    output logic                          o_valid,
    output logic signed [2*COORD_BITS+2:0] o_den,
    output logic signed [2*COORD_BITS+2:0] o_tn,
    output logic signed [2*COORD_BITS+2:0] o_un
);
    import sip_pkg::*;

    localparam int DW = COORD_BITS + 1;       // difference width
    localparam int PW = 2 * COORD_BITS + 2;   // product width
    localparam int XW = 2 * COORD_BITS + 3;   // cross product width

    // stage 1: differences
    logic                 r_v1;
    logic signed [DW-1:0] r_dx12, r_dy12, r_dx34, r_dy34, r_dx13, r_dy13;
    logic signed [DW-1:0] n_dx12, n_dy12, n_dx34, n_dy34, n_dx13, n_dy13;

    // stage 2: products
    logic                 r_v2;
    logic signed [PW-1:0] r_pda, r_pdb, r_pta, r_ptb, r_pua, r_pub;
    logic signed [PW-1:0] n_pda, n_pdb, n_pta, n_ptb, n_pua, n_pub;

    // stage 3: cross products
    logic                 r_v3;
    logic signed [XW-1:0] r_den, r_tn, r_un;
    logic signed [XW-1:0] n_den, n_tn, n_un;

    always_comb begin
        n_dx12 = DW'(i_x1) - DW'(i_x2);
        n_dy12 = DW'(i_y1) - DW'(i_y2);
        n_dx34 = DW'(i_x3) - DW'(i_x4);
        n_dy34 = DW'(i_y3) - DW'(i_y4);
        n_dx13 = DW'(i_x1) - DW'(i_x3);
        n_dy13 = DW'(i_y1) - DW'(i_y3);

        n_pda = PW'(r_dx12) * PW'(r_dy34);
        n_pdb = PW'(r_dy12) * PW'(r_dx34);
        n_pta = PW'(r_dx13) * PW'(r_dy34);
        n_ptb = PW'(r_dy13) * PW'(r_dx34);
        n_pua = PW'(r_dy12) * PW'(r_dx13);
        n_pub = PW'(r_dx12) * PW'(r_dy13);

        n_den = XW'(r_pda) - XW'(r_pdb);
        n_tn  = XW'(r_pta) - XW'(r_ptb);
        n_un  = XW'(r_pua) - XW'(r_pub);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx12 <= n_dx12;
        r_dy12 <= n_dy12;
        r_dx34 <= n_dx34;
        r_dy34 <= n_dy34;
        r_dx13 <= n_dx13;
        r_dy13 <= n_dy13;
        r_pda  <= n_pda;
        r_pdb  <= n_pdb;
        r_pta  <= n_pta;
        r_ptb  <= n_ptb;
        r_pua  <= n_pua;
        r_pub  <= n_pub;
        r_den  <= n_den;
        r_tn   <= n_tn;
        r_un   <= n_un;
    end

    assign o_valid = r_v3;
    assign o_den   = r_den;
    assign o_tn    = r_tn;
    assign o_un    = r_un;

endmodule

### hdl/sip_test.sv
module sip_test #(
    parameter int COORD_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic signed [2*COORD_BITS+2:0]  i_den,
    input  logic signed [2*COORD_BITS+2:0]  i_tn,
    input  logic signed [2*COORD_BITS+2:0]  i_un,
    output sip_pkg::t_ctl                   o_ctl,
    output logic [2*COORD_BITS+1:0]         o_rem,
    output logic [2*COORD_BITS+1:0]         o_den
);
    import sip_pkg::*;

    localparam int XW = 2 * COORD_BITS + 3;
    localparam int W  = XW - 1;

    t_ctl         r_ctl, n_ctl;
    logic [W-1:0] r_rem, r_den;

    always_comb begin
        n_ctl.valid = i_valid;
        n_ctl.hit   = (i_den > XW'(0)) && !i_tn[XW-1] && (i_tn <= i_den)
                      && !i_un[XW-1] && (i_un <= i_den);
        n_ctl.full  = (i_un == i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    // on a hit both values are non-negative, so the sign bit drops away
    always_ff @(posedge i_clk) begin
        r_rem <= i_un[W-1:0];
        r_den <= i_den[W-1:0];
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_den = r_den;

endmodule

### hdl/sip_div.sv
module sip_div #(
    parameter int W = 34,
    parameter int F = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sip_pkg::t_ctl i_ctl,
    input  logic [W-1:0]  i_rem,
    input  logic [W-1:0]  i_den,
    output sip_pkg::t_ctl o_ctl,
    output logic [F-1:0]  o_quo
);
    import sip_pkg::*;

    // restoring division, one quotient bit per stage; rem <= den on entry for a hit
    t_ctl         s_ctl [F+1];
    wire  [W-1:0] s_rem [F+1];
    wire  [W-1:0] s_den [F+1];
    wire  [F-1:0] s_quo [F+1];

    assign s_ctl[0] = i_ctl;
    assign s_rem[0] = i_rem;
    assign s_den[0] = i_den;
    assign s_quo[0] = '0;

    for (genvar g = 0; g < F; g++) begin : g_stage
        t_ctl         r_ctl;
        logic [W-1:0] r_rem, n_rem;
        logic [W-1:0] r_den;
        logic [F-1:0] r_quo, n_quo;
        logic [W:0]   n_sh, n_diff;
        logic         n_ge;

        always_comb begin
            n_sh   = {s_rem[g], 1'b0};
            n_diff = n_sh - {1'b0, s_den[g]};
            n_ge   = (n_sh >= {1'b0, s_den[g]});
            n_rem  = n_ge ? n_diff[W-1:0] : n_sh[W-1:0];
            n_quo  = {s_quo[g][F-2:0], n_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl <= '0;
            end else begin
                r_ctl <= s_ctl[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem <= n_rem;
            r_den <= s_den[g];
            r_quo <= n_quo;
        end

        assign s_ctl[g+1] = r_ctl;
        assign s_rem[g+1] = r_rem;
        assign s_den[g+1] = r_den;
        assign s_quo[g+1] = r_quo;
    end

    assign o_ctl = s_ctl[F];
    assign o_quo = s_quo[F];

endmodule

### hdl/segment_intersection_param_unit.sv
// Channel   | Handshake               | Payload
// ----------+-------------------------+--------------------------------------------
// request   | start, busy             | i_travel_*, i_surface_* (COORD_BITS, signed)
// result    | o_done (one-cycle pulse)| o_hit, o_surface_fraction (FRACTION_BITS+1)
//
// One request can be taken every cycle; busy stays low.
// Registered steps in order: differences, multipliers, cross products,
// range test, one restoring divider stage per fraction bit, output register.
// The divider pipeline sets the depth; every stage passes one request per cycle.
// Synchronous active-low reset clears the valid and control bits only.
// The receiver cannot stall, so nothing in the pipe ever waits.
module segment_intersection_param_unit #(
    parameter int COORD_BITS    = 16,
    parameter int FRACTION_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_BITS-1:0]   i_travel_start_x,
    input  logic signed [COORD_BITS-1:0]   i_travel_start_y,
    input  logic signed [COORD_BITS-1:0]   i_travel_end_x,
    input  logic signed [COORD_BITS-1:0]   i_travel_end_y,
    input  logic signed [COORD_BITS-1:0]   i_surface_start_x,
    input  logic signed [COORD_BITS-1:0]   i_surface_start_y,
    input  logic signed [COORD_BITS-1:0]   i_surface_end_x,
    input  logic signed [COORD_BITS-1:0]   i_surface_end_y,
    output logic                           o_done,
    output logic                           o_hit,
    output logic [FRACTION_BITS:0]         o_surface_fraction
);
    import sip_pkg::*;

    localparam int XW = 2 * COORD_BITS + 3;
    localparam int W  = XW - 1;

    logic                 x_valid;
    logic signed [XW-1:0] x_den, x_tn, x_un;
    t_ctl                 tst_ctl;
    logic [W-1:0]         tst_rem, tst_den;
    t_ctl                 d_ctl;
    logic [FRACTION_BITS-1:0] d_quo;

    logic                   r_done, r_hit;
    logic [FRACTION_BITS:0] r_frac, n_frac;

    assign busy = 1'b0;

    sip_cross #(
        .COORD_BITS (COORD_BITS)
    ) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_x1    (i_travel_start_x),
        .i_y1    (i_travel_start_y),
        .i_x2    (i_travel_end_x),
        .i_y2    (i_travel_end_y),
        .i_x3    (i_surface_start_x),
        .i_y3    (i_surface_start_y),
        .i_x4    (i_surface_end_x),
        .i_y4    (i_surface_end_y),
        .o_valid (x_valid),
        .o_den   (x_den),
        .o_tn    (x_tn),
        .o_un    (x_un)
    );

    sip_test #(
        .COORD_BITS (COORD_BITS)
    ) u_test (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (x_valid),
        .i_den   (x_den),
        .i_tn    (x_tn),
        .i_un    (x_un),
        .o_ctl   (tst_ctl),
        .o_rem   (tst_rem),
        .o_den   (tst_den)
    );

    sip_div #(
        .W (W),
        .F (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tst_ctl),
        .i_rem   (tst_rem),
        .i_den   (tst_den),
        .o_ctl   (d_ctl),
        .o_quo   (d_quo)
    );

    always_comb begin
        if (!d_ctl.hit) begin
            n_frac = '0;
        end else if (d_ctl.full) begin
            n_frac = {1'b1, {FRACTION_BITS{1'b0}}};
        end else begin
            n_frac = {1'b0, d_quo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= d_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit  <= d_ctl.hit;
        r_frac <= n_frac;
    end

    assign o_done             = r_done;
    assign o_hit              = r_hit;
    assign o_surface_fraction = r_frac;

endmodule
